[src/smfd_pkg.sv]
// shared types, constants and fixed-point helpers for the stereo modulated delay
// no dependencies
package smfd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_STEP  = 3'd7;

  localparam int Q_FROZEN      = 65208;
  localparam int Q_FREEZE_WET  = 44564;
  localparam int Q_STUTTER_WET = 60293;
  localparam int Q_DRY_WET     = 18350;
  localparam int Q_DRY_STUTTER = 61604;
  localparam int LIM_FEEDBACK  = 44564;
  localparam int LIM_CROSS     = 60293;
  localparam int LIM_WET       = 44564;
  localparam int LIM_UNITY     = 65536;
  localparam int KNEE_Q15      = 30147;
  localparam int CEIL_Q15      = 32604;
  localparam int HEAD_Q15      = CEIL_Q15 - KNEE_Q15;

  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_Q_W   = 16;

  typedef struct packed {
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
    logic [16:0]        freeze_amount;
    logic [16:0]        stutter_amount;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } out_t;

  // shift right rounding half away from zero
  function automatic logic signed [47:0] rsh(input logic signed [47:0] x,
                                             input int unsigned s);
    logic [47:0] mag;
    logic [47:0] r;
    mag = x[47] ? 48'(-x) : 48'(x);
    r = (mag + (48'd1 << (s - 1))) >> s;
    return x[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [47:0] qmul(input logic signed [47:0] a,
                                              input logic signed [47:0] b,
                                              input int unsigned s);
    return rsh(a * b, s);
  endfunction

  function automatic logic signed [47:0] blend(input logic signed [47:0] a,
                                               input logic signed [47:0] b,
                                               input logic [16:0] g);
    return a + rsh((b - a) * $signed(48'(g)), 16);
  endfunction

  function automatic logic signed [16:0] interp(input logic [15:0] a,
                                                input logic [15:0] b,
                                                input logic [7:0] f);
    logic signed [47:0] d;
    logic signed [47:0] r;
    d = 48'($signed(b)) - 48'($signed(a));
    r = 48'($signed(a)) + rsh(d * $signed(48'(f)), 8);
    return r[16:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [47:0] v);
    logic [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'h7fff;
    end else if (v < -48'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[src/smfd_div.sv]
// restoring divider, one quotient bit per cycle
// depends on smfd_pkg
module smfd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [smfd_pkg::DIV_NUM_W-1:0] num,
  input  logic [smfd_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [smfd_pkg::DIV_Q_W-1:0]   quo
);
  import smfd_pkg::*;

  localparam int SW = DIV_DEN_W + DIV_Q_W;
  localparam int CW = $clog2(DIV_Q_W);

  logic [SW-1:0]        rem_r;
  logic [SW-1:0]        dsh_r;
  logic [DIV_Q_W-1:0]   quo_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 take;

  assign take = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= SW'(num);
        dsh_r  <= {den, {(DIV_Q_W-1){1'b0}}, 1'b0} >> 1;
      end else if (busy_r) begin
        if (take) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[DIV_Q_W-2:0], take};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/smfd_store.sv]
// two-channel echo memory with registered read and clearing sweep after reset
// no dependencies
module smfd_store #(
  parameter int DEPTH = 524288,
  parameter int AW    = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic          ready
);

  logic [31:0]   mem_r [DEPTH];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clearing_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clearing_r;

endmodule

[src/stereo_modulated_feedback_delay.sv]
// top level: sequencer and datapath of the stereo cross-feedback delay
// depends on smfd_pkg, smfd_div, smfd_store
//
//   channel | ports                           | transfer
//   input   | in_valid, in_ready, in_data     | valid and ready high at clk edge
//   result  | out_valid, out_ready, out_data  | valid and ready high at clk edge
//   config  | cfg_we, cfg_index, cfg_data     | write enable high at clk edge
//
// one item at a time: in_ready stays low from the input transfer until the result is
// registered; each soft ceiling that divides makes the sequence wait on the divider again
// the sequence uses the 16-step divider (sine, then one per channel) and six memory reads
// after reset a clearing sweep over all DELAY_DEPTH entries runs with in_ready low
// a finished result waits in the output register; the next item is taken meanwhile
module stereo_modulated_feedback_delay #(
  parameter int DELAY_DEPTH     = 524288,
  parameter int STUTTER_TAP     = 6000,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smfd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output smfd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [smfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import smfd_pkg::*;

  localparam int AW       = $clog2(DELAY_DEPTH);
  localparam int TW       = AW + 8;
  localparam int PW       = 30;
  localparam int SPAN     = DELAY_DEPTH * 256;
  localparam int TAP_HI   = (DELAY_DEPTH - 2) * 256;
  localparam int STAP_RAW = STUTTER_TAP * 256;
  localparam int STAP     = STAP_RAW > TAP_HI ? TAP_HI : (STAP_RAW < 256 ? 256 : STAP_RAW);
  localparam int SB       = SINE_TABLE_BITS;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SR0   = 5'd1;
  localparam logic [4:0] ST_SR1   = 5'd2;
  localparam logic [4:0] ST_SR2   = 5'd3;
  localparam logic [4:0] ST_WSIN  = 5'd4;
  localparam logic [4:0] ST_MOD   = 5'd5;
  localparam logic [4:0] ST_RL0   = 5'd6;
  localparam logic [4:0] ST_RL1   = 5'd7;
  localparam logic [4:0] ST_RR0   = 5'd8;
  localparam logic [4:0] ST_RR1   = 5'd9;
  localparam logic [4:0] ST_RB    = 5'd10;
  localparam logic [4:0] ST_INTP  = 5'd11;
  localparam logic [4:0] ST_STU   = 5'd12;
  localparam logic [4:0] ST_MIXL  = 5'd13;
  localparam logic [4:0] ST_MIXR  = 5'd14;
  localparam logic [4:0] ST_FB    = 5'd15;
  localparam logic [4:0] ST_FRZ   = 5'd16;
  localparam logic [4:0] ST_BLEND = 5'd17;
  localparam logic [4:0] ST_CL    = 5'd18;
  localparam logic [4:0] ST_WCL   = 5'd19;
  localparam logic [4:0] ST_CR    = 5'd20;
  localparam logic [4:0] ST_WCR   = 5'd21;
  localparam logic [4:0] ST_WR    = 5'd22;
  localparam logic [4:0] ST_DRY   = 5'd23;
  localparam logic [4:0] ST_OUT   = 5'd24;

  // configuration
  logic [26:0] tap_left_r, tap_right_r;
  logic [15:0] feedback_gain_r, cross_gain_r, wet_gain_r, mod_depth_r;
  logic [16:0] level_gain_r;
  logic [23:0] mod_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_left_r      <= 27'd76800;
      tap_right_r     <= 27'd76800;
      feedback_gain_r <= '0;
      cross_gain_r    <= '0;
      wet_gain_r      <= '0;
      level_gain_r    <= 17'd65536;
      mod_depth_r     <= '0;
      mod_step_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_LEFT:  tap_left_r      <= cfg_data;
        REG_TAP_RIGHT: tap_right_r     <= cfg_data;
        REG_FEEDBACK:  feedback_gain_r <= cfg_data[15:0];
        REG_CROSS:     cross_gain_r    <= cfg_data[15:0];
        REG_WET:       wet_gain_r      <= cfg_data[15:0];
        REG_LEVEL:     level_gain_r    <= cfg_data[16:0];
        REG_MOD_DEPTH: mod_depth_r     <= cfg_data[15:0];
        REG_MOD_STEP:  mod_step_r      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [15:0] fb, cr, wg;
  logic [16:0] lv, fz_in, st_in;

  assign fb    = feedback_gain_r > 16'(LIM_FEEDBACK) ? 16'(LIM_FEEDBACK) : feedback_gain_r;
  assign cr    = cross_gain_r > 16'(LIM_CROSS) ? 16'(LIM_CROSS) : cross_gain_r;
  assign wg    = wet_gain_r > 16'(LIM_WET) ? 16'(LIM_WET) : wet_gain_r;
  assign lv    = level_gain_r > 17'(LIM_UNITY) ? 17'(LIM_UNITY) : level_gain_r;
  assign fz_in = in_data.freeze_amount > 17'(LIM_UNITY) ? 17'(LIM_UNITY)
                                                       : in_data.freeze_amount;
  assign st_in = in_data.stutter_amount > 17'(LIM_UNITY) ? 17'(LIM_UNITY)
                                                        : in_data.stutter_amount;

  // state and item registers
  logic [4:0]           state_r;
  logic [AW-1:0]        wi_r;
  logic [31:0]          phase_r;
  logic signed [15:0]   xl_r, xr_r;
  logic [16:0]          st_r, frz_r;
  logic [15:0]          famt_r, wet0_r, w3_r, wet_r;
  logic [16:0]          g1_r, g2_r, dry_r;
  logic signed [33:0]   modprod_r;
  logic [TW-1:0]        tapl_r, tapr_r;
  logic [31:0]          sa_r, sb_r;
  logic [15:0]          la_r, lb_r, ra_r, rb_r;
  logic signed [16:0]   el_r, er_r, sl_r, sr_r;
  logic signed [16:0]   el2_r, er2_r;
  logic signed [17:0]   mixl_r, mixr_r, frl_r, frr_r;
  logic signed [19:0]   dl_r, dr_r;
  logic [15:0]          cl_r, cr_out_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  // memory and divider hookup
  logic [AW-1:0]        rd_addr;
  logic [31:0]          rd_data;
  logic                 wr_en;
  logic                 store_ready;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quo;

  function automatic logic [TW-1:0] wrap_pos(input logic [TW-1:0] tap,
                                             input logic [AW-1:0] wi);
    logic signed [PW-1:0] p;
    p = $signed(PW'({wi, 8'h00})) - $signed(PW'(tap));
    if (p < 0) begin
      p = p + $signed(PW'(SPAN));
    end
    return p[TW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    return (a == AW'(DELAY_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [TW-1:0] clamp_tap(input logic signed [PW-1:0] v);
    logic [TW-1:0] r;
    if (v < $signed(PW'(256))) begin
      r = TW'(256);
    end else if (v > $signed(PW'(TAP_HI))) begin
      r = TW'(TAP_HI);
    end else begin
      r = v[TW-1:0];
    end
    return r;
  endfunction

  logic [TW-1:0] pos_s, pos_l, pos_r;
  assign pos_s = wrap_pos(TW'(STAP), wi_r);
  assign pos_l = wrap_pos(tapl_r, wi_r);
  assign pos_r = wrap_pos(tapr_r, wi_r);

  // sine by rational approximation, divided in the shared unit
  logic [SB-2:0]        sin_r;
  logic [15:0]          sin_t;
  logic [32:0]          sin_prod;
  logic [16:0]          sin_u;
  logic [DIV_DEN_W-1:0] sin_den;
  logic [DIV_NUM_W-1:0] sin_num;
  logic                 halfbit;

  assign halfbit  = phase_r[31];
  assign sin_r    = phase_r[31-1 -: SB-1];
  assign sin_t    = 16'(sin_r) << (17 - SB);
  assign sin_prod = 33'(sin_t) * (33'd65536 - 33'(sin_t));
  assign sin_u    = sin_prod[32:16];
  assign sin_den  = DIV_DEN_W'(327680) - DIV_DEN_W'({sin_u, 2'b00});
  assign sin_num  = DIV_NUM_W'(sin_u) << 19;

  // soft ceiling operands
  logic signed [19:0]   csel;
  logic [19:0]          cmag, cex;
  logic                 cbig;
  logic [DIV_NUM_W-1:0] c_num;
  logic [DIV_DEN_W-1:0] c_den;
  logic [15:0]          c_m;

  assign csel  = (state_r == ST_CL || state_r == ST_WCL) ? dl_r : dr_r;
  assign cmag  = csel[19] ? 20'(-csel) : 20'(csel);
  assign cbig  = cmag > 20'(KNEE_Q15);
  assign cex   = cmag - 20'(KNEE_Q15);
  assign c_num = DIV_NUM_W'(cex) * DIV_NUM_W'(HEAD_Q15);
  assign c_den = cex + DIV_DEN_W'(HEAD_Q15);
  assign c_m   = 16'(KNEE_Q15) + div_quo;

  logic signed [16:0] sine_s;
  logic signed [47:0] mod48;
  logic signed [PW-1:0] sum_l, sum_r;

  assign sine_s = halfbit ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign mod48  = rsh(48'(modprod_r), 15);
  assign sum_l  = $signed(PW'(tap_left_r)) + PW'(mod48);
  assign sum_r  = $signed(PW'(tap_right_r)) - PW'(mod48);

  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && store_ready;

  always_comb begin
    div_start = 1'b0;
    div_num   = sin_num;
    div_den   = sin_den;
    if (accept) begin
      div_start = 1'b1;
    end else if ((state_r == ST_CL || state_r == ST_CR) && cbig) begin
      div_start = 1'b1;
      div_num   = c_num;
      div_den   = c_den;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_SR0:  rd_addr = pos_s[TW-1:8];
      ST_SR1:  rd_addr = next_addr(pos_s[TW-1:8]);
      ST_RL0:  rd_addr = pos_l[TW-1:8];
      ST_RL1:  rd_addr = next_addr(pos_l[TW-1:8]);
      ST_RR0:  rd_addr = pos_r[TW-1:8];
      ST_RR1:  rd_addr = next_addr(pos_r[TW-1:8]);
      default: rd_addr = pos_s[TW-1:8];
    endcase
  end

  assign wr_en = state_r == ST_WR;

  logic signed [47:0] xl48, xr48, el48, er48, mixl48, mixr48, cr48, ncr48;
  assign xl48   = 48'(xl_r);
  assign xr48   = 48'(xr_r);
  assign el48   = 48'(el2_r);
  assign er48   = 48'(er2_r);
  assign mixl48 = 48'(mixl_r);
  assign mixr48 = 48'(mixr_r);
  assign cr48   = $signed(48'(cr));
  assign ncr48  = $signed(48'd65536) - cr48;

  logic [15:0] w2;
  assign w2 = 16'(qmul($signed(48'(frz_r)), 48'(Q_FREEZE_WET), 16));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wi_r        <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            xl_r    <= in_data.in_left;
            xr_r    <= in_data.in_right;
            st_r    <= st_in;
            frz_r   <= fz_in > st_in ? fz_in : st_in;
            state_r <= ST_SR0;
          end
        end
        ST_SR0: state_r <= ST_SR1;
        ST_SR1: begin
          sa_r    <= rd_data;
          famt_r  <= 16'(qmul($signed(48'(fb)), $signed(48'(lv)), 16));
          wet0_r  <= 16'(qmul($signed(48'(wg)), $signed(48'(lv)), 16));
          state_r <= ST_SR2;
        end
        ST_SR2: begin
          sb_r    <= rd_data;
          w3_r    <= 16'(qmul($signed(48'(st_r)), 48'(Q_STUTTER_WET), 16));
          g2_r    <= 17'($signed(48'd65536)
                     - qmul($signed(48'(st_r)), 48'(Q_DRY_STUTTER), 16));
          state_r <= ST_WSIN;
        end
        ST_WSIN: begin
          if (div_done) begin
            modprod_r <= sine_s * $signed({1'b0, mod_depth_r});
            state_r   <= ST_MOD;
          end
        end
        ST_MOD: begin
          tapl_r  <= clamp_tap(sum_l);
          tapr_r  <= clamp_tap(sum_r);
          state_r <= ST_RL0;
        end
        ST_RL0: state_r <= ST_RL1;
        ST_RL1: begin
          la_r    <= rd_data[15:0];
          state_r <= ST_RR0;
        end
        ST_RR0: begin
          lb_r    <= rd_data[15:0];
          state_r <= ST_RR1;
        end
        ST_RR1: begin
          ra_r    <= rd_data[31:16];
          state_r <= ST_RB;
        end
        ST_RB: begin
          rb_r    <= rd_data[31:16];
          state_r <= ST_INTP;
        end
        ST_INTP: begin
          el_r    <= interp(la_r, lb_r, pos_l[7:0]);
          er_r    <= interp(ra_r, rb_r, pos_r[7:0]);
          sl_r    <= interp(sa_r[15:0], sb_r[15:0], pos_s[7:0]);
          sr_r    <= interp(sa_r[31:16], sb_r[31:16], pos_s[7:0]);
          state_r <= ST_STU;
        end
        ST_STU: begin
          el2_r   <= 17'(blend(48'(el_r), 48'(sl_r), st_r));
          er2_r   <= 17'(blend(48'(er_r), 48'(sr_r), st_r));
          state_r <= ST_MIXL;
        end
        ST_MIXL: begin
          mixl_r  <= 18'(rsh(el48 * ncr48 + er48 * cr48, 16));
          state_r <= ST_MIXR;
        end
        ST_MIXR: begin
          mixr_r  <= 18'(rsh(er48 * ncr48 + el48 * cr48, 16));
          state_r <= ST_FB;
        end
        ST_FB: begin
          dl_r    <= 20'(xl48 + qmul($signed(48'(famt_r)), mixl48, 16));
          dr_r    <= 20'(xr48 + qmul($signed(48'(famt_r)), mixr48, 16));
          state_r <= ST_FRZ;
        end
        ST_FRZ: begin
          frl_r   <= 18'(qmul(mixl48, 48'(Q_FROZEN), 16));
          frr_r   <= 18'(qmul(mixr48, 48'(Q_FROZEN), 16));
          state_r <= ST_BLEND;
        end
        ST_BLEND: begin
          dl_r    <= 20'(blend(48'(dl_r), 48'(frl_r), frz_r));
          dr_r    <= 20'(blend(48'(dr_r), 48'(frr_r), frz_r));
          if (w2 > wet0_r && w2 >= w3_r) begin
            wet_r <= w2;
          end else if (w3_r > wet0_r) begin
            wet_r <= w3_r;
          end else begin
            wet_r <= wet0_r;
          end
          state_r <= ST_CL;
        end
        ST_CL: begin
          if (cbig) begin
            state_r <= ST_WCL;
          end else begin
            cl_r    <= dl_r[15:0];
            state_r <= ST_CR;
          end
        end
        ST_WCL: begin
          if (div_done) begin
            cl_r    <= csel[19] ? -c_m : c_m;
            state_r <= ST_CR;
          end
        end
        ST_CR: begin
          if (cbig) begin
            state_r <= ST_WCR;
          end else begin
            cr_out_r <= dr_r[15:0];
            state_r  <= ST_WR;
          end
        end
        ST_WCR: begin
          if (div_done) begin
            cr_out_r <= csel[19] ? -c_m : c_m;
            state_r  <= ST_WR;
          end
        end
        ST_WR: begin
          g1_r    <= 17'($signed(48'd65536)
                     - qmul($signed(48'(wet_r)), 48'(Q_DRY_WET), 16));
          state_r <= ST_DRY;
        end
        ST_DRY: begin
          dry_r   <= 17'(qmul($signed(48'(g1_r)), $signed(48'(g2_r)), 16));
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.out_left  <= sat16(rsh(xl48 * $signed(48'(dry_r))
                                        + el48 * $signed(48'(wet_r)), 16));
            out_data_r.out_right <= sat16(rsh(xr48 * $signed(48'(dry_r))
                                        + er48 * $signed(48'(wet_r)), 16));
            out_valid_r <= 1'b1;
            wi_r        <= next_addr(wi_r);
            phase_r     <= phase_r + 32'(mod_step_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smfd_store #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wi_r),
    .wr_data ({cr_out_r, cl_r}),
    .ready   (store_ready)
  );

  smfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
